// ===== sv/texture_slot_binder_with_batch_flush_core_assert.svh =====
// Assertion macros for the checker file of the texture slot binder.
`ifndef TEXTURE_SLOT_BINDER_WITH_BATCH_FLUSH_CORE_ASSERT_SVH
`define TEXTURE_SLOT_BINDER_WITH_BATCH_FLUSH_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is held low.
`define TSB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tsb assertion failed");

// Clocked assertion that also holds while reset is applied.
`define TSB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tsb assertion failed");

`endif

// ===== sv/tsb_pkg.sv =====
package tsb_pkg;

    localparam int TEX_W            = 32;
    localparam int SLOT_W           = 6;
    localparam int IDX_W            = 15;
    localparam int INDICES_PER_QUAD = 6;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic search;
        logic write;
    } t_tab_ctl;

    typedef struct packed {
        logic done;
        logic hit;
    } t_tab_sts;

endpackage

// ===== sv/tsb_slot_table.sv =====
module tsb_slot_table
    import tsb_pkg::*;
#(
    parameter int MAX_SLOTS = 32,
    parameter int SW        = 6,
    parameter int AW        = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tab_ctl         i_ctl,
    input  logic [TEX_W-1:0] i_tex,
    input  logic [SW-1:0]    i_used,
    input  logic [AW-1:0]    i_wr_addr,
    output t_tab_sts         o_sts,
    output logic [SW-1:0]    o_slot
);

    logic [TEX_W-1:0] r_mem [MAX_SLOTS];
    logic [TEX_W-1:0] r_rdata;
    logic             r_active;
    logic             r_pend;
    logic [SW-1:0]    r_idx;

    logic rd_en;
    logic hit_now;
    logic done_now;

    // One entry is read per cycle; the comparator checks the entry read in the
    // previous cycle, so the slot of a hit is the current read index.
    assign rd_en    = r_active && (r_idx < i_used);
    assign hit_now  = r_pend && (r_rdata == i_tex);
    assign done_now = r_active && (hit_now || (r_idx >= i_used));

    assign o_sts.done = done_now;
    assign o_sts.hit  = hit_now;
    assign o_slot     = r_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_mem[i_wr_addr] <= i_tex;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pend   <= 1'b0;
            r_idx    <= '0;
        end else if (i_ctl.search) begin
            r_active <= 1'b1;
            r_pend   <= 1'b0;
            r_idx    <= '0;
        end else if (r_active) begin
            if (done_now) begin
                r_active <= 1'b0;
                r_pend   <= 1'b0;
            end else begin
                r_idx  <= r_idx + SW'(1);
                r_pend <= 1'b1;
            end
        end
    end

endmodule

// ===== sv/texture_slot_binder_with_batch_flush_core.sv =====
// A draw or an untextured push goes from idle to the finish state and its result strobe is
// registered from there; a textured push first searches the slots in use (at most MAX_SLOTS).
// A new item is taken only in idle; start may be raised again in the strobe cycle.
// The serial search reads one slot table entry per cycle through one comparator.
// Reset is synchronous and active low: counts, sequencer and strobe clear at once;
// the slot table keeps its contents. The receiver cannot stall the result strobe.
module texture_slot_binder_with_batch_flush_core
    import tsb_pkg::*;
#(
    parameter int MAX_SLOTS = 32,
    parameter int MAX_QUADS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_op,
    input  logic [TEX_W-1:0]  i_tex_id,
    output logic              o_busy,
    output logic              o_valid,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_flushed,
    output logic [IDX_W-1:0]  o_drawn_indices,
    output logic [SLOT_W-1:0] o_drawn_textures,
    output logic [IDX_W-1:0]  o_batch_indices,
    output logic              o_overflow
);

    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int IW = $clog2(MAX_QUADS * INDICES_PER_QUAD + 1);
    localparam logic [IW:0]   IDX_LIMIT = (IW + 1)'(MAX_QUADS * INDICES_PER_QUAD);
    localparam logic [SW-1:0] SLOT_FULL = SW'(MAX_SLOTS);

    t_state r_state;
    t_state n_state;

    logic             r_op;
    logic [TEX_W-1:0] r_tex;
    logic [SW-1:0]    r_used;
    logic [IW-1:0]    r_total;
    logic             r_hit;
    logic [SW-1:0]    r_hit_slot;

    logic              r_valid;
    logic [SLOT_W-1:0] r_slot;
    logic              r_flushed;
    logic [IDX_W-1:0]  r_drawn_idx;
    logic [SLOT_W-1:0] r_drawn_tex;
    logic [IDX_W-1:0]  r_batch_idx;
    logic              r_ovf;

    t_tab_ctl      tab_ctl;
    t_tab_sts      tab_sts;
    logic [SW-1:0] tab_slot;

    logic          accept;
    logic          textured;
    logic          flush_now;
    logic          append_now;
    logic [SW-1:0] base_used;
    logic [IW-1:0] base_total;
    logic [IW:0]   idx_sum;
    logic          ovf_now;
    logic [SW-1:0] n_used;
    logic [IW-1:0] n_total;
    logic [SW-1:0] slot_val;

    logic [SW+SLOT_W-1:0] slot_ext;
    logic [SW+SLOT_W-1:0] dtex_ext;
    logic [IW+IDX_W-1:0]  didx_ext;
    logic [IW+IDX_W-1:0]  bidx_ext;

    assign accept   = i_start && (r_state == S_IDLE);
    assign textured = (r_tex != '0);

    // A miss with every slot taken draws the batch before the new id goes in.
    always_comb begin
        flush_now  = (r_op == OP_DRAW) || (textured && !r_hit && (r_used >= SLOT_FULL));
        append_now = (r_op == OP_PUSH) && textured && !r_hit;
        base_used  = flush_now ? '0 : r_used;
        base_total = flush_now ? '0 : r_total;
        idx_sum    = {1'b0, base_total} + (IW + 1)'(INDICES_PER_QUAD);
        ovf_now    = (idx_sum > IDX_LIMIT);
        if (r_op == OP_DRAW) begin
            n_used   = '0;
            n_total  = '0;
            slot_val = '0;
        end else begin
            n_used   = append_now ? (base_used + SW'(1)) : r_used;
            n_total  = ovf_now ? IDX_LIMIT[IW-1:0] : idx_sum[IW-1:0];
            if (append_now) begin
                slot_val = base_used + SW'(1);
            end else if (textured) begin
                slot_val = r_hit_slot;
            end else begin
                slot_val = '0;
            end
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, slot_val};
    assign dtex_ext = {{SLOT_W{1'b0}}, r_used};
    assign didx_ext = {{IDX_W{1'b0}}, r_total};
    assign bidx_ext = {{IDX_W{1'b0}}, n_total};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if ((i_op == OP_PUSH) && (i_tex_id != '0)) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SEARCH: begin
                if (tab_sts.done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy         = 1'b1;
        tab_ctl.search = 1'b0;
        tab_ctl.write  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy         = 1'b0;
                tab_ctl.search = i_start && (i_op == OP_PUSH) && (i_tex_id != '0);
            end
            S_SEARCH: begin
                o_busy = 1'b1;
            end
            S_FINISH: begin
                tab_ctl.write = append_now;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    tsb_slot_table #(
        .MAX_SLOTS (MAX_SLOTS),
        .SW        (SW),
        .AW        (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tab_ctl),
        .i_tex     (r_tex),
        .i_used    (r_used),
        .i_wr_addr (base_used[AW-1:0]),
        .o_sts     (tab_sts),
        .o_slot    (tab_slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_FINISH);
            if (r_state == S_FINISH) begin
                r_used  <= n_used;
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_tex <= i_tex_id;
            r_hit <= 1'b0;
        end else if ((r_state == S_SEARCH) && tab_sts.done) begin
            r_hit      <= tab_sts.hit;
            r_hit_slot <= tab_slot;
        end
        if (r_state == S_FINISH) begin
            r_slot      <= slot_ext[SLOT_W-1:0];
            r_flushed   <= flush_now;
            r_drawn_idx <= flush_now ? didx_ext[IDX_W-1:0] : '0;
            r_drawn_tex <= flush_now ? dtex_ext[SLOT_W-1:0] : '0;
            r_batch_idx <= bidx_ext[IDX_W-1:0];
            r_ovf       <= (r_op == OP_PUSH) && ovf_now;
        end
    end

    assign o_valid          = r_valid;
    assign o_slot           = r_slot;
    assign o_flushed        = r_flushed;
    assign o_drawn_indices  = r_drawn_idx;
    assign o_drawn_textures = r_drawn_tex;
    assign o_batch_indices  = r_batch_idx;
    assign o_overflow       = r_ovf;

endmodule

// ===== sv/tsb_checker.sv =====
`include "texture_slot_binder_with_batch_flush_core_assert.svh"

module tsb_checker
    import tsb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              i_op,
    input logic [TEX_W-1:0]  i_tex_id,
    input logic              o_busy,
    input logic              o_valid,
    input logic [SLOT_W-1:0] o_slot,
    input logic              o_flushed,
    input logic [IDX_W-1:0]  o_drawn_indices,
    input logic [SLOT_W-1:0] o_drawn_textures,
    input logic [IDX_W-1:0]  o_batch_indices,
    input logic              o_overflow
);

    // A transfer in always makes the block busy in the cycle after it.
    `TSB_ASSERT(a_busy_after_start, i_clk, i_rst_n, (i_start && !o_busy) |=> o_busy)

    // Drawn counts are only reported by an item that drew a batch.
    `TSB_ASSERT(a_drawn_zero, i_clk, i_rst_n, (o_valid && !o_flushed) |-> ((o_drawn_indices == '0) && (o_drawn_textures == '0)))

    // A freshly drawn batch cannot already be at the index limit.
    `TSB_ASSERT(a_no_ovf_on_flush, i_clk, i_rst_n, (o_valid && o_overflow) |-> !o_flushed)

    // Results are strobes of a single cycle.
    `TSB_ASSERT(a_single_strobe, i_clk, i_rst_n, o_valid |=> !o_valid)

endmodule

bind texture_slot_binder_with_batch_flush_core tsb_checker u_tsb_checker (.*);
